// File: rtl/bfplw_pkg.sv
// ----------------------------------------------------------------------------
// bfplw_pkg
// Shared constants for the band factor pair left-weighting block: the
// nibble packing of the factor words.
// ----------------------------------------------------------------------------
package bfplw_pkg;

  // Factor words are packed four bits per strand
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned FIELD_NIBS = 8;
  localparam int unsigned FIELD_W    = NIB_W * FIELD_NIBS;

endpackage

// File: rtl/bfplw_cycle_round.sv
// ----------------------------------------------------------------------------
// bfplw_cycle_round
// One pointer-doubling round of the cycle labelling. Squares the permutation
// power and merges the running maxima over the window, then registers both.
// ----------------------------------------------------------------------------
module bfplw_cycle_round #(
  parameter int unsigned N  = 8,
  parameter int unsigned IW = 3
) (
  input  logic                   clk_i,
  input  logic [N-1:0][IW-1:0]   perm_i,
  input  logic [N-1:0][IW-1:0]   max_i,
  output logic [N-1:0][IW-1:0]   perm_o,
  output logic [N-1:0][IW-1:0]   max_o
);

  logic [N-1:0][IW-1:0] perm_d, perm_q;
  logic [N-1:0][IW-1:0] max_d, max_q;

  // Double the walk: p' = p o p, m'(x) = max(m(x), m(p(x)))
  always_comb begin
    for (int unsigned x = 0; x < N; x++) begin
      perm_d[x] = perm_i[perm_i[x]];
      max_d[x]  = (max_i[perm_i[x]] > max_i[x]) ? max_i[perm_i[x]] : max_i[x];
    end
  end

  // Hold the round result for the next stage
  always_ff @(posedge clk_i) begin
    perm_q <= perm_d;
    max_q  <= max_d;
  end

  assign perm_o = perm_q;
  assign max_o  = max_q;

endmodule

// File: rtl/band_factor_pair_left_weighting.sv
// ----------------------------------------------------------------------------
// band_factor_pair_left_weighting
// Left-weighting step on a pair of adjacent band-generator canonical factors.
// ----------------------------------------------------------------------------
// Fully pipelined: a new factor pair is taken in every cycle (busy_o stays
// low) and its result word appears on the outputs, marked by done_o for one
// cycle, after passing through the unpacking stage, the pointer-doubling
// rounds that label the cycles of both permutations, one round per stage,
// and the stages for class comparison, meet selection and composition. The
// receiver cannot stall the block, so done_o must be taken when it shows.
// Invalid permutations, and pairs whose meet is the identity, pass through
// unchanged with changed_o low.
// ----------------------------------------------------------------------------
module band_factor_pair_left_weighting #(
  parameter int unsigned STRANDS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [bfplw_pkg::FIELD_W-1:0] left_factor_i,
  input  logic [bfplw_pkg::FIELD_W-1:0] right_factor_i,
  output logic                         done_o,
  output logic [bfplw_pkg::FIELD_W-1:0] new_left_factor_o,
  output logic [bfplw_pkg::FIELD_W-1:0] new_right_factor_o,
  output logic                         changed_o
);

  localparam int unsigned N   = STRANDS;
  localparam int unsigned IW  = (STRANDS > 1) ? $clog2(STRANDS) : 1;
  localparam int unsigned LG  = $clog2(STRANDS);
  localparam int unsigned LAT = LG + 4;
  localparam int unsigned NW  = bfplw_pkg::NIB_W;
  localparam int unsigned FN  = bfplw_pkg::FIELD_NIBS;
  localparam int unsigned FW  = bfplw_pkg::FIELD_W;
  localparam int unsigned OUT_NIBS = (N < FN) ? N : FN;
  localparam logic [NW:0] NS = (NW + 1)'(STRANDS);

  // Word carried alongside the labelling datapath
  typedef struct packed {
    logic [FW-1:0]        a;
    logic [FW-1:0]        b;
    logic [N-1:0][IW-1:0] lp;
    logic [N-1:0][IW-1:0] rp;
    logic                 ok;
  } carry_t;

  // --------------------------------------------------------------------------
  // Stage 1: unpack, validate, invert L and rotate by delta
  // --------------------------------------------------------------------------
  logic [N-1:0][NW-1:0] lnib, rnib;
  logic [N-1:0]         lseen, rseen;
  logic                 lrange, rrange;
  carry_t               s1_d;
  logic [N-1:0][IW-1:0] linv, ls_d;
  carry_t               s1_q;
  logic [N-1:0][IW-1:0] ls_q;
  logic                 s1_vld_q;

  always_comb begin
    lseen  = '0;
    rseen  = '0;
    lrange = 1'b1;
    rrange = 1'b1;
    for (int unsigned k = 0; k < N; k++) begin
      if (k < FN) begin
        lnib[k] = left_factor_i[(k % FN)*NW +: NW];
        rnib[k] = right_factor_i[(k % FN)*NW +: NW];
      end else begin
        lnib[k] = '0;
        rnib[k] = '0;
      end
      if ({1'b0, lnib[k]} >= NS) lrange = 1'b0;
      if ({1'b0, rnib[k]} >= NS) rrange = 1'b0;
      for (int unsigned v = 0; v < N; v++) begin
        if (lnib[k] == NW'(v)) lseen[v] = 1'b1;
        if (rnib[k] == NW'(v)) rseen[v] = 1'b1;
      end
    end
    s1_d.a  = left_factor_i;
    s1_d.b  = right_factor_i;
    s1_d.ok = lrange && rrange && (&lseen) && (&rseen);
    for (int unsigned k = 0; k < N; k++) begin
      s1_d.lp[k] = lnib[k][IW-1:0];
      s1_d.rp[k] = rnib[k][IW-1:0];
    end
    // Scatter L into its inverse
    for (int unsigned t = 0; t < N; t++) begin
      linv[t] = '0;
      for (int unsigned k = 0; k < N; k++) begin
        if (s1_d.lp[k] == IW'(t)) linv[t] = linv[t] | IW'(k);
      end
    end
    // L*(x) = L^-1(delta(x))
    for (int unsigned x = 0; x < N; x++) begin
      ls_d[x] = (x == 0) ? linv[N-1] : linv[(x + N - 1) % N];
    end
  end

  // Advance stage 1
  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    ls_q <= ls_d;
  end

  // --------------------------------------------------------------------------
  // Doubling rounds: label each element with the largest member of its cycle
  // --------------------------------------------------------------------------
  logic [N-1:0][IW-1:0] lsp [LG+1];
  logic [N-1:0][IW-1:0] lsm [LG+1];
  logic [N-1:0][IW-1:0] rpp [LG+1];
  logic [N-1:0][IW-1:0] rpm [LG+1];
  carry_t               rc_q [LG+1];
  logic [LG:0]          rv_q;

  always_comb begin
    for (int unsigned x = 0; x < N; x++) begin
      lsm[0][x] = IW'(x);
      rpm[0][x] = IW'(x);
    end
  end
  assign lsp[0]  = ls_q;
  assign rpp[0]  = s1_q.rp;
  assign rc_q[0] = s1_q;
  assign rv_q[0] = s1_vld_q;

  genvar j;
  generate
    for (j = 0; j < LG; j++) begin : g_round
      logic   vld_q;
      carry_t carry_q;

      bfplw_cycle_round #(.N(N), .IW(IW)) u_lround (
        .clk_i  (clk_i),
        .perm_i (lsp[j]),
        .max_i  (lsm[j]),
        .perm_o (lsp[j+1]),
        .max_o  (lsm[j+1])
      );

      bfplw_cycle_round #(.N(N), .IW(IW)) u_rround (
        .clk_i  (clk_i),
        .perm_i (rpp[j]),
        .max_i  (rpm[j]),
        .perm_o (rpp[j+1]),
        .max_o  (rpm[j+1])
      );

      // Carry the word and its valid bit beside the round
      always_ff @(posedge clk_i) begin
        carry_q <= rc_q[j];
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q <= 1'b0;
        end else begin
          vld_q <= rv_q[j];
        end
      end

      assign rc_q[j+1] = carry_q;
      assign rv_q[j+1] = vld_q;
    end
  endgenerate

  // --------------------------------------------------------------------------
  // Class stage: compare label pairs
  // --------------------------------------------------------------------------
  logic [N-1:0][N-1:0] eq_d, eq_q;
  carry_t              ce_q;
  logic                ce_vld_q;

  always_comb begin
    for (int unsigned x = 0; x < N; x++) begin
      for (int unsigned y = 0; y < N; y++) begin
        eq_d[x][y] = (lsm[LG][x] == lsm[LG][y]) && (rpm[LG][x] == rpm[LG][y]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eq_q <= eq_d;
    ce_q <= rc_q[LG];
  end

  // --------------------------------------------------------------------------
  // Meet stage: next smaller class member, smallest wraps to largest
  // --------------------------------------------------------------------------
  logic [N-1:0][IW-1:0] mp_d, mp_q;
  logic [N-1:0][IW-1:0] lo, hi;
  logic [N-1:0]         found;
  logic                 ident;
  logic                 chg_d;
  carry_t               cp_q;
  logic                 chg_q;
  logic                 cp_vld_q;

  always_comb begin
    ident = 1'b1;
    for (int unsigned x = 0; x < N; x++) begin
      lo[x]    = '0;
      hi[x]    = IW'(x);
      found[x] = 1'b0;
      for (int unsigned y = 0; y < N; y++) begin
        if (eq_q[x][y]) begin
          if (y < x) begin
            lo[x]    = IW'(y);
            found[x] = 1'b1;
          end else begin
            hi[x] = IW'(y);
          end
        end
      end
      mp_d[x] = found[x] ? lo[x] : hi[x];
      if (mp_d[x] != IW'(x)) ident = 1'b0;
    end
    chg_d = ce_q.ok && !ident;
  end

  always_ff @(posedge clk_i) begin
    mp_q  <= mp_d;
    cp_q  <= ce_q;
    chg_q <= chg_d;
  end

  // --------------------------------------------------------------------------
  // Output stage: L o M and M^-1 o R, or pass through
  // --------------------------------------------------------------------------
  logic [N-1:0][IW-1:0] minv, nl, nr;
  logic [FW-1:0]        nl_word, nr_word;
  logic [FW-1:0]        left_d, right_d, left_q, right_q;
  logic                 changed_q;
  logic                 done_q;

  always_comb begin
    for (int unsigned t = 0; t < N; t++) begin
      minv[t] = '0;
      for (int unsigned x = 0; x < N; x++) begin
        if (mp_q[x] == IW'(t)) minv[t] = minv[t] | IW'(x);
      end
    end
    for (int unsigned x = 0; x < N; x++) begin
      nl[x] = cp_q.lp[mp_q[x]];
      nr[x] = minv[cp_q.rp[x]];
    end
    nl_word = '0;
    nr_word = '0;
    for (int unsigned k = 0; k < OUT_NIBS; k++) begin
      nl_word[k*NW +: NW] = NW'(nl[k]);
      nr_word[k*NW +: NW] = NW'(nr[k]);
    end
    left_d  = chg_q ? nl_word : cp_q.a;
    right_d = chg_q ? nr_word : cp_q.b;
  end

  always_ff @(posedge clk_i) begin
    left_q    <= left_d;
    right_q   <= right_d;
    changed_q <= chg_q;
  end

  // Advance the valid bits of the fixed stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      ce_vld_q <= 1'b0;
      cp_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
      ce_vld_q <= rv_q[LG];
      cp_vld_q <= ce_vld_q;
      done_q   <= cp_vld_q;
    end
  end

  assign busy_o             = 1'b0;
  assign done_o             = done_q;
  assign new_left_factor_o  = left_q;
  assign new_right_factor_o = right_q;
  assign changed_o          = changed_q && done_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_changed_with_done : assert property (
    @(posedge clk_i) disable iff (!rst_ni) changed_o |-> done_o
  ) else $error("changed_o raised without a result word");

  a_pass_through : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (done_o && !changed_o) |->
        (new_left_factor_o == $past(left_factor_i, LAT)) &&
        (new_right_factor_o == $past(right_factor_i, LAT))
  ) else $error("unchanged word does not match its input pair");

  a_left_moves : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (done_o && changed_o) |-> (new_left_factor_o != $past(left_factor_i, LAT))
  ) else $error("non-trivial meet left the left factor untouched");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the band factor pair left-weighting step. A short
// table of hand-picked factor pairs (identity, cyclic shifts, broken
// permutations, identity meets) is followed by random pairs, mostly valid
// permutations with some duplicated or out-of-range strands and raw noise.
// Each accepted pair gets its typed expectation or a prediction from an
// in-bench model of the meet, compared field by field with the block's word.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned STRANDS      = 8;
  localparam int          RANDOM_ITEMS = 2000;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES = 24;
  localparam logic [bfplw_pkg::FIELD_W-1:0] IDENTITY_FACTOR = 32'h7654_3210;

  typedef logic [STRANDS-1:0][bfplw_pkg::NIB_W-1:0] strand_map_t;

  typedef struct packed {
    logic [bfplw_pkg::FIELD_W-1:0] new_left;
    logic [bfplw_pkg::FIELD_W-1:0] new_right;
    logic                          changed;
  } meet_result_t;

  typedef struct {
    logic [bfplw_pkg::FIELD_W-1:0] left;
    logic [bfplw_pkg::FIELD_W-1:0] right;
    bit                            typed;
    meet_result_t                  expected;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic [bfplw_pkg::FIELD_W-1:0] left_factor_i = '0;
  logic [bfplw_pkg::FIELD_W-1:0] right_factor_i = '0;
  logic                          done_o;
  logic [bfplw_pkg::FIELD_W-1:0] new_left_factor_o;
  logic [bfplw_pkg::FIELD_W-1:0] new_right_factor_o;
  logic                          changed_o;

  // Typed expectation travelling alongside the word on the input ports
  bit                 row_typed = 1'b0;
  meet_result_t       row_expected = '0;

  meet_result_t       pending_results[$];
  stim_row_t          directed_rows[$];
  int                 fail_count = 0;
  int                 idle_cycles = 0;
  int                 quiet_burst = 0;

  band_factor_pair_left_weighting #(
    .STRANDS(STRANDS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .left_factor_i     (left_factor_i),
    .right_factor_i    (right_factor_i),
    .done_o            (done_o),
    .new_left_factor_o (new_left_factor_o),
    .new_right_factor_o(new_right_factor_o),
    .changed_o         (changed_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Meet predictor
  // --------------------------------------------------------------------------

  // Unpack a factor word; reject out-of-range or repeated strands
  function automatic bit decode_factor(input logic [bfplw_pkg::FIELD_W-1:0] w,
                                       output strand_map_t p);
    logic [STRANDS-1:0] seen;
    int                 v;
    seen = '0;
    p    = '0;
    for (int k = 0; k < STRANDS; k++) begin
      v = (k < bfplw_pkg::FIELD_NIBS) ?
          int'(w[bfplw_pkg::NIB_W*k +: bfplw_pkg::NIB_W]) : 0;
      if (v >= STRANDS || seen[v]) return 1'b0;
      seen[v] = 1'b1;
      p[k]    = bfplw_pkg::NIB_W'(v);
    end
    return 1'b1;
  endfunction

  // Tag every strand with the largest strand of its cycle
  function automatic strand_map_t label_cycles(input strand_map_t p);
    strand_map_t lab;
    int          y;
    int          m;
    lab = '0;
    for (int x = 0; x < STRANDS; x++) begin
      y = x;
      m = x;
      for (int s = 0; s < STRANDS; s++) begin
        y = int'(p[y]);
        if (y > m) m = y;
      end
      lab[x] = bfplw_pkg::NIB_W'(m);
    end
    return lab;
  endfunction

  function automatic meet_result_t predict_left_weighting(
      input logic [bfplw_pkg::FIELD_W-1:0] lw,
      input logic [bfplw_pkg::FIELD_W-1:0] rw);
    strand_map_t  lp, rp, linv, lstar, lab_l, lab_r, meet, meet_inv;
    meet_result_t res;
    bit           below;
    bit           ident;
    int           pick;
    int           d;
    res.new_left  = lw;
    res.new_right = rw;
    res.changed   = 1'b0;
    linv          = '0;
    meet_inv      = '0;
    if (!decode_factor(lw, lp) || !decode_factor(rw, rp)) return res;

    // Lstar = L^-1 o delta, delta stepping each strand down by one
    for (int x = 0; x < STRANDS; x++) linv[lp[x]] = bfplw_pkg::NIB_W'(x);
    for (int x = 0; x < STRANDS; x++) begin
      d        = (x == 0) ? STRANDS - 1 : x - 1;
      lstar[x] = linv[d];
    end
    lab_l = label_cycles(lstar);
    lab_r = label_cycles(rp);

    // Send each strand to the next smaller one of its class, smallest wraps
    ident = 1'b1;
    for (int x = 0; x < STRANDS; x++) begin
      below = 1'b0;
      pick  = x;
      for (int y = 0; y < x; y++) begin
        if (lab_l[y] == lab_l[x] && lab_r[y] == lab_r[x]) begin
          pick  = y;
          below = 1'b1;
        end
      end
      if (!below) begin
        for (int y = x; y < STRANDS; y++) begin
          if (lab_l[y] == lab_l[x] && lab_r[y] == lab_r[x]) pick = y;
        end
      end
      meet[x] = bfplw_pkg::NIB_W'(pick);
      if (pick != x) ident = 1'b0;
    end
    if (ident) return res;

    for (int x = 0; x < STRANDS; x++) meet_inv[meet[x]] = bfplw_pkg::NIB_W'(x);
    res.new_left  = '0;
    res.new_right = '0;
    for (int x = 0; x < STRANDS && x < bfplw_pkg::FIELD_NIBS; x++) begin
      res.new_left[bfplw_pkg::NIB_W*x +: bfplw_pkg::NIB_W]  = lp[meet[x]];
      res.new_right[bfplw_pkg::NIB_W*x +: bfplw_pkg::NIB_W] = meet_inv[rp[x]];
    end
    res.changed = 1'b1;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Shuffle the strands; nibbles above the strand count carry noise
  function automatic logic [bfplw_pkg::FIELD_W-1:0] random_factor();
    strand_map_t                   p;
    logic [bfplw_pkg::FIELD_W-1:0] w;
    logic [bfplw_pkg::NIB_W-1:0]   t;
    int                            j;
    for (int k = 0; k < STRANDS; k++) p[k] = bfplw_pkg::NIB_W'(k);
    for (int k = STRANDS - 1; k > 0; k--) begin
      j    = $urandom_range(k, 0);
      t    = p[k];
      p[k] = p[j];
      p[j] = t;
    end
    w = $urandom();
    for (int k = 0; k < STRANDS && k < bfplw_pkg::FIELD_NIBS; k++) begin
      w[bfplw_pkg::NIB_W*k +: bfplw_pkg::NIB_W] = p[k];
    end
    return w;
  endfunction

  // Mostly short gaps, a few long ones, and bursts with none at all
  function automatic int pick_gap();
    int roll;
    if (quiet_burst > 0) begin
      quiet_burst--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet_burst = $urandom_range(20, 100);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input logic [bfplw_pkg::FIELD_W-1:0] l,
                         input logic [bfplw_pkg::FIELD_W-1:0] r,
                         input bit typed, input logic [bfplw_pkg::FIELD_W-1:0] el,
                         input logic [bfplw_pkg::FIELD_W-1:0] er, input logic ec);
    stim_row_t row;
    row.left               = l;
    row.right              = r;
    row.typed              = typed;
    row.expected.new_left  = el;
    row.expected.new_right = er;
    row.expected.changed   = ec;
    directed_rows.push_back(row);
  endtask

  // Present one word and hold it until the block takes it
  task automatic issue_pair(input logic [bfplw_pkg::FIELD_W-1:0] l,
                            input logic [bfplw_pkg::FIELD_W-1:0] r,
                            input bit typed, input meet_result_t exp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    left_factor_i  <= l;
    right_factor_i <= r;
    row_typed      <= typed;
    row_expected   <= exp;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: queue predictions on acceptance, compare on done
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    meet_result_t exp;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with none expected (left %h right %h changed %b)",
                   $time, new_left_factor_o, new_right_factor_o, changed_o);
          fail_count++;
        end else begin
          exp = pending_results.pop_front();
          if (new_left_factor_o !== exp.new_left) begin
            $display("%0t: new_left_factor expected %h got %h",
                     $time, exp.new_left, new_left_factor_o);
            fail_count++;
          end
          if (new_right_factor_o !== exp.new_right) begin
            $display("%0t: new_right_factor expected %h got %h",
                     $time, exp.new_right, new_right_factor_o);
            fail_count++;
          end
          if (changed_o !== exp.changed) begin
            $display("%0t: changed expected %b got %b", $time, exp.changed, changed_o);
            fail_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        if (row_typed) pending_results.push_back(row_expected);
        else pending_results.push_back(predict_left_weighting(left_factor_i, right_factor_i));
      end
    end
  end

  // Watchdog: stop when no word moves either way for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [bfplw_pkg::FIELD_W-1:0] l;
    logic [bfplw_pkg::FIELD_W-1:0] r;
    logic [bfplw_pkg::FIELD_W-1:0] w;
    meet_result_t                  blank;
    int                            roll;
    int                            i;
    int                            j;
    blank = '0;

    // Identity meets and broken permutations pass straight through
    add_row(32'h7654_3210, 32'h7654_3210, 1'b1, 32'h7654_3210, 32'h7654_3210, 1'b0);
    add_row(32'h0123_4567, 32'h7654_3210, 1'b1, 32'h0123_4567, 32'h7654_3210, 1'b0);
    add_row(32'h5476_1032, 32'h7654_3210, 1'b1, 32'h5476_1032, 32'h7654_3210, 1'b0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_row(32'h7654_3210, 32'h8654_3210, 1'b1, 32'h7654_3210, 32'h8654_3210, 1'b0);
    add_row(32'h7654_3218, 32'h0765_4321, 1'b1, 32'h7654_3218, 32'h0765_4321, 1'b0);
    add_row(32'h7654_3211, 32'h7654_3210, 1'b1, 32'h7654_3211, 32'h7654_3210, 1'b0);
    add_row(32'hF654_3210, 32'h0765_4321, 1'b1, 32'hF654_3210, 32'h0765_4321, 1'b0);
    add_row(32'h0765_4321, 32'h7654_321F, 1'b1, 32'h0765_4321, 32'h7654_321F, 1'b0);
    // Remaining rows are checked against the predictor
    add_row(32'h7654_3210, 32'h7654_3201, 1'b0, '0, '0, 1'b0);
    add_row(32'h7654_3210, 32'h0765_4321, 1'b0, '0, '0, 1'b0);
    add_row(32'h0765_4321, 32'h0765_4321, 1'b0, '0, '0, 1'b0);
    add_row(32'h6543_2107, 32'h0123_4567, 1'b0, '0, '0, 1'b0);
    add_row(32'h0123_4567, 32'h0123_4567, 1'b0, '0, '0, 1'b0);
    add_row(32'h1076_5432, 32'h3210_7654, 1'b0, '0, '0, 1'b0);
    add_row(32'h7654_3210, 32'h6745_2301, 1'b0, '0, '0, 1'b0);
    add_row(32'h1234_5670, 32'h1234_5670, 1'b0, '0, '0, 1'b0);
    add_row(32'h6745_2301, 32'h5476_1032, 1'b0, '0, '0, 1'b0);

    // Hold reset, then release on an edge
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[n]) begin
      issue_pair(directed_rows[n].left, directed_rows[n].right,
                 directed_rows[n].typed, directed_rows[n].expected);
    end

    // Random pairs: mostly valid permutations, then corrupted and raw words
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      l    = random_factor();
      r    = random_factor();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        r = IDENTITY_FACTOR;
      end else if (roll < 12) begin
        l = 32'h6543_2107;
      end else if (roll < 20) begin
        // Copy one strand over another
        w = $urandom_range(0, 1) ? l : r;
        i = $urandom_range(0, STRANDS - 1);
        j = $urandom_range(0, STRANDS - 2);
        if (j >= i) j++;
        w[bfplw_pkg::NIB_W*j +: bfplw_pkg::NIB_W] = w[bfplw_pkg::NIB_W*i +: bfplw_pkg::NIB_W];
        if ($urandom_range(0, 1)) l = w;
        else r = w;
      end else if (roll < 26) begin
        // Push one strand out of range
        i = $urandom_range(0, STRANDS - 1);
        if ($urandom_range(0, 1)) begin
          l[bfplw_pkg::NIB_W*i +: bfplw_pkg::NIB_W] =
            bfplw_pkg::NIB_W'($urandom_range(STRANDS, 15));
        end else begin
          r[bfplw_pkg::NIB_W*i +: bfplw_pkg::NIB_W] =
            bfplw_pkg::NIB_W'($urandom_range(STRANDS, 15));
        end
      end else if (roll < 32) begin
        l = $urandom();
        r = $urandom();
      end
      issue_pair(l, r, 1'b0, blank);
    end
    start_i <= 1'b0;

    // Drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
